// ===== hw/rtl/dtoi_pkg.sv =====
// Shared types, character codes and limits for the decimal text to int32 unit.
package dtoi_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned WIDE_W  = 36;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

    localparam logic [WIDE_W-1:0] POS_LIMIT = 36'd2147483647;

    typedef enum logic [4:0] {
        PH_LEAD   = 5'b00001,
        PH_SIGNED = 5'b00010,
        PH_DIGITS = 5'b00100,
        PH_TRAIL  = 5'b01000,
        PH_ERROR  = 5'b10000
    } phase_t;

    function automatic logic is_ws(input logic [CHAR_W-1:0] c);
        return ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

// ===== hw/rtl/decimal_text_to_int32_unit.sv =====
// Top level: streaming parser of signed decimal text into a 32-bit integer.
//
// Usage:
//   Slave channel (s_axis_*) takes the text one byte per item. tdata[7:0]
//   is the byte, tlast marks the final byte, tuser flags an empty-text
//   item (it also ends the text and its byte is ignored).
//   Master channel (m_axis_*) gives one item per text: tdata is the signed
//   value, tuser is the parse-ok flag (value is 0 when the flag is low).
//   Throughput: one item per cycle in both directions while m_axis does
//   not stall, no bubbles between texts. The byte scanner is one registered
//   step: input register, then a x10 accumulate with a limit compare into
//   the state and result regs. A text's result appears on m_axis after its
//   ending byte has passed the input register and then the result register.
//   Reset clears the scan state to leading whitespace and empties both
//   registers. When the receiver stalls, the result holds and s_axis keeps
//   accepting bytes that end no text; a byte that ends a text waits in the
//   input register until the result register frees up.
module decimal_text_to_int32_unit
    import dtoi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [CHAR_W-1:0]   s_axis_tdata,  // [7:0] char_byte
    input  logic                s_axis_tlast,  // last_byte
    input  logic                s_axis_tuser,  // [0] empty_marker
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [VALUE_W-1:0]  m_axis_tdata,  // [31:0] result_value
    output logic                m_axis_tuser   // [0] parse_ok
);

    logic                in_valid_reg;
    logic [CHAR_W-1:0]   in_byte_reg;
    logic                in_last_reg;
    logic                in_empty_reg;

    phase_t              phase_reg, phase_next;
    logic                neg_reg, neg_next;
    logic [VALUE_W-1:0]  acc_reg, acc_next;

    logic                out_valid_reg;
    logic [VALUE_W-1:0]  out_value_reg, out_value_next;
    logic                out_ok_reg, out_ok_next;

    logic                ends_text;
    logic                out_free;
    logic                advance;
    logic [3:0]          digit;
    logic [WIDE_W-1:0]   acc_wide;
    logic [WIDE_W-1:0]   sum_wide;
    logic [WIDE_W-1:0]   limit;
    logic                fits;
    phase_t              phase_scan;
    logic                neg_scan;
    logic [VALUE_W-1:0]  acc_scan;

    assign ends_text     = in_last_reg || in_empty_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!ends_text || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    assign digit    = 4'(in_byte_reg - CHAR_ZERO);
    assign acc_wide = {{(WIDE_W-VALUE_W){1'b0}}, acc_reg};
    assign sum_wide = (acc_wide << 3) + (acc_wide << 1) + {{(WIDE_W-4){1'b0}}, digit};
    assign limit    = POS_LIMIT + {{(WIDE_W-1){1'b0}}, neg_reg};
    assign fits     = sum_wide <= limit;

    // one byte of the scanner
    always_comb
    begin
        phase_scan = phase_reg;
        neg_scan   = neg_reg;
        acc_scan   = acc_reg;
        if (!in_empty_reg)
        begin
            case (phase_reg)
                PH_LEAD:
                begin
                    if (is_ws(in_byte_reg))
                    begin
                        phase_scan = PH_LEAD;
                    end
                    else if (in_byte_reg == CHAR_PLUS)
                    begin
                        phase_scan = PH_SIGNED;
                    end
                    else if (in_byte_reg == CHAR_MINUS)
                    begin
                        phase_scan = PH_SIGNED;
                        neg_scan   = 1'b1;
                    end
                    else if (is_digit(in_byte_reg))
                    begin
                        phase_scan = fits ? PH_DIGITS : PH_ERROR;
                        if (fits)
                            acc_scan = sum_wide[VALUE_W-1:0];
                    end
                    else
                    begin
                        phase_scan = PH_ERROR;
                    end
                end
                PH_SIGNED, PH_DIGITS:
                begin
                    if (is_digit(in_byte_reg))
                    begin
                        phase_scan = fits ? PH_DIGITS : PH_ERROR;
                        if (fits)
                            acc_scan = sum_wide[VALUE_W-1:0];
                    end
                    else if (is_ws(in_byte_reg) && (phase_reg == PH_DIGITS))
                    begin
                        phase_scan = PH_TRAIL;
                    end
                    else
                    begin
                        phase_scan = PH_ERROR;
                    end
                end
                PH_TRAIL:
                begin
                    if (!is_ws(in_byte_reg))
                        phase_scan = PH_ERROR;
                end
                default:
                begin
                    phase_scan = PH_ERROR;
                end
            endcase
        end
    end

    always_comb
    begin
        out_ok_next    = (phase_scan == PH_DIGITS) || (phase_scan == PH_TRAIL);
        out_value_next = '0;
        if (out_ok_next)
            out_value_next = neg_scan ? (VALUE_W'(0) - acc_scan) : acc_scan;
        if (ends_text)
        begin
            phase_next = PH_LEAD;
            neg_next   = 1'b0;
            acc_next   = '0;
        end
        else
        begin
            phase_next = phase_scan;
            neg_next   = neg_scan;
            acc_next   = acc_scan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_LEAD;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
            end
            if (advance && ends_text)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_last_reg  <= s_axis_tlast;
            in_empty_reg <= s_axis_tuser;
        end
        if (advance && ends_text)
        begin
            out_value_reg <= out_value_next;
            out_ok_reg    <= out_ok_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_ok_reg;

    a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("failed parse carries a nonzero value");

    a_end_resets_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && ends_text) |=> (phase_reg == PH_LEAD && !neg_reg && acc_reg == '0))
        else $error("scan state not cleared after text end");

    a_lead_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LEAD) |-> (!neg_reg && acc_reg == '0))
        else $error("leading phase with stale sign or magnitude");

    a_signed_no_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SIGNED) |-> (acc_reg == '0))
        else $error("sign phase with nonzero magnitude");

    a_end_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && ends_text && out_valid_reg && !m_axis_tready) |-> !advance)
        else $error("text end consumed while result register full");

endmodule

// ===== sim/decimal_text_to_int32_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for decimal_text_to_int32_unit: directed and random texts checked against a local parser.
module decimal_text_to_int32_unit_tb
    import dtoi_pkg::*;
();

    localparam int unsigned ITEM_TARGET = 1100;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned TAIL_CYCLES = 10;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              empty;
        int unsigned       gap;
        bit                drain;
    } text_item_t;

    typedef struct {
        logic               ok;
        logic [VALUE_W-1:0] value;
    } parsed_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [CHAR_W-1:0]  s_axis_tdata = '0;   // [7:0] char_byte
    logic               s_axis_tlast = 1'b0; // last_byte
    logic               s_axis_tuser = 1'b0; // [0] empty_marker
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [VALUE_W-1:0] m_axis_tdata;        // [31:0] result_value
    logic               m_axis_tuser;        // [0] parse_ok

    text_item_t         feed_q[$];
    parsed_t            parse_due[$];
    logic [CHAR_W-1:0]  txt[$];
    text_item_t         on_wire;

    phase_t             scan_ph = PH_LEAD;
    bit                 scan_neg = 1'b0;
    logic [VALUE_W-1:0] scan_mag = '0;

    int unsigned items_total = 0;
    int unsigned items_taken = 0;
    int unsigned texts_total = 0;
    int unsigned results_seen = 0;
    int unsigned ok_seen = 0;
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned wait_left = 0;
    int unsigned stall_left = 0;
    bit          in_fire = 1'b0;
    bit          out_fire = 1'b0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    bit          drain_next = 1'b0;

    decimal_text_to_int32_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------- parser prediction ----------------

    function automatic bit blank_char(input logic [CHAR_W-1:0] c);
        return (c > 8'd8 && c < 8'd14) || c == CHAR_SPACE;
    endfunction

    function automatic bit digit_char(input logic [CHAR_W-1:0] c);
        return c[7:4] == 4'h3 && c[3:0] < 4'd10;
    endfunction

    task automatic take_digit(input logic [CHAR_W-1:0] c);
        logic [63:0] nxt;
        logic [63:0] cap;
        nxt = {32'd0, scan_mag};
        nxt = nxt * 64'd10 + {60'd0, c[3:0]};
        cap = scan_neg ? 64'd2147483648 : 64'd2147483647;
        if (nxt > cap)
        begin
            scan_ph = PH_ERROR;
        end
        else
        begin
            scan_mag = nxt[VALUE_W-1:0];
            scan_ph = PH_DIGITS;
        end
    endtask

    task automatic scan_char(input logic [CHAR_W-1:0] c);
        case (scan_ph)
            PH_LEAD:
            begin
                if (blank_char(c))
                    scan_ph = PH_LEAD;
                else if (c == CHAR_PLUS)
                    scan_ph = PH_SIGNED;
                else if (c == CHAR_MINUS)
                begin
                    scan_neg = 1'b1;
                    scan_ph = PH_SIGNED;
                end
                else if (digit_char(c))
                    take_digit(c);
                else
                    scan_ph = PH_ERROR;
            end
            PH_SIGNED:
            begin
                if (digit_char(c))
                    take_digit(c);
                else
                    scan_ph = PH_ERROR;
            end
            PH_DIGITS:
            begin
                if (digit_char(c))
                    take_digit(c);
                else if (blank_char(c))
                    scan_ph = PH_TRAIL;
                else
                    scan_ph = PH_ERROR;
            end
            PH_TRAIL:
            begin
                if (!blank_char(c))
                    scan_ph = PH_ERROR;
            end
            default:
                scan_ph = PH_ERROR;
        endcase
    endtask

    task automatic predict_text(input logic [CHAR_W-1:0] c, input logic last,
                                input logic empty);
        parsed_t r;
        if (!empty)
            scan_char(c);
        if (last || empty)
        begin
            r.ok = (scan_ph == PH_DIGITS) || (scan_ph == PH_TRAIL);
            r.value = !r.ok ? '0 : (scan_neg ? -scan_mag : scan_mag);
            parse_due = {parse_due, r};
            scan_ph = PH_LEAD;
            scan_neg = 1'b0;
            scan_mag = '0;
        end
    endtask

    // ---------------- checking ----------------

    task automatic flag_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        errors++;
    endtask

    task automatic check_result();
        parsed_t want;
        if (parse_due.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected result ok=%0b value=%0d",
                                    m_axis_tuser, $signed(m_axis_tdata)));
        end
        else
        begin
            want = parse_due.pop_front();
            if (m_axis_tuser !== want.ok)
                flag_mismatch($sformatf("parse_ok %0b, want %0b", m_axis_tuser, want.ok));
            if (m_axis_tdata !== want.value)
                flag_mismatch($sformatf("result_value %0d, want %0d",
                                        $signed(m_axis_tdata), $signed(want.value)));
            results_seen++;
            if (want.ok)
                ok_seen++;
        end
    endtask

    always @(posedge clk)
    begin
        in_fire <= s_axis_tvalid && s_axis_tready;
        out_fire <= m_axis_tvalid && m_axis_tready;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_text(s_axis_tdata, s_axis_tlast, s_axis_tuser);
                items_taken++;
            end
            if (m_axis_tvalid && m_axis_tready)
                check_result();
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL decimal_text_to_int32_unit");
            $finish;
        end
    end

    // ---------------- driver and receiver ----------------

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_fire)
            begin
                if (wait_left != 0)
                begin
                    wait_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (feed_q.size() == 0 || (feed_q[0].drain && parse_due.size() != 0))
                begin
                    s_axis_tvalid <= 1'b0;
                end
                else if (feed_q[0].gap != 0)
                begin
                    wait_left = feed_q[0].gap - 1;
                    feed_q[0].gap = 0;
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    on_wire = feed_q.pop_front();
                    s_axis_tdata <= on_wire.ch;
                    s_axis_tlast <= on_wire.last;
                    s_axis_tuser <= on_wire.empty;
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
            begin
                if ($urandom_range(0, 15) == 0)
                    rx_calm = !rx_calm;
                stall_left = rx_calm ? 0 : $urandom_range(0, 3);
            end
            if (stall_left != 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------- stimulus ----------------

    function automatic int unsigned next_gap();
        return tx_calm ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_blank();
        int unsigned k;
        logic [CHAR_W-1:0] b;
        k = $urandom_range(0, 5);
        b = 8'(k + 9);
        return (k == 5) ? CHAR_SPACE : b;
    endfunction

    function automatic longint unsigned pick_mag();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 99);
            1:       return $urandom_range(0, 999999);
            2:       return 64'd2147483645 + $urandom_range(0, 5);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_char(input logic [CHAR_W-1:0] c);
        txt = {txt, c};
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    task automatic send_text(input bit end_empty);
        text_item_t it;
        int n;
        int start;
        n = txt.size();
        start = feed_q.size();
        for (int i = 0; i < n; i++)
        begin
            it.ch = txt[i];
            it.last = (i == n - 1) && !end_empty;
            it.empty = 1'b0;
            it.gap = next_gap();
            it.drain = 1'b0;
            feed_q = {feed_q, it};
        end
        if (end_empty || n == 0)
        begin
            it.ch = 8'($urandom_range(0, 255));
            it.last = 1'($urandom_range(0, 1));
            it.empty = 1'b1;
            it.gap = next_gap();
            it.drain = 1'b0;
            feed_q = {feed_q, it};
        end
        feed_q[start].drain = drain_next;
        drain_next = 1'b0;
        items_total += feed_q.size() - start;
        texts_total++;
        txt.delete();
    endtask

    task automatic build_number();
        int unsigned sel;
        repeat ($urandom_range(0, 2))
            add_char(pick_blank());
        sel = $urandom_range(0, 2);
        if (sel == 1)
            add_char(CHAR_PLUS);
        else if (sel == 2)
            add_char(CHAR_MINUS);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2))
                add_char(CHAR_ZERO);
        put_str($sformatf("%0d", pick_mag()));
        repeat ($urandom_range(0, 2))
            add_char(pick_blank());
    endtask

    initial
    begin
        int unsigned kind;
        int unsigned pos;

        // directed: empty, limits, overflow, signs, blanks, bad bytes, empty ending
        send_text(1'b1);
        put_str("2147483647");
        send_text(1'b0);
        put_str("-2147483648");
        send_text(1'b0);
        put_str("2147483648");
        send_text(1'b0);
        put_str("-2147483649");
        send_text(1'b0);
        put_str("+0");
        send_text(1'b0);
        for (int k = 9; k <= 13; k++)
            add_char(8'(k));
        add_char(CHAR_SPACE);
        put_str("42");
        add_char(CHAR_TAB);
        add_char(CHAR_SPACE);
        send_text(1'b0);
        put_str("  ");
        send_text(1'b0);
        put_str("-");
        send_text(1'b0);
        put_str("- 5");
        send_text(1'b0);
        put_str("12 34");
        send_text(1'b0);
        put_str("+-1");
        send_text(1'b0);
        add_char(8'hFF);
        send_text(1'b0);
        put_str("7");
        add_char(8'h00);
        send_text(1'b0);
        put_str("77");
        send_text(1'b1);
        put_str("99999999999 ");
        send_text(1'b0);

        drain_next = 1'b1;
        while (items_total < ITEM_TARGET)
        begin
            if ($urandom_range(0, 39) == 0)
                tx_calm = !tx_calm;
            if ($urandom_range(0, 49) == 0)
                drain_next = 1'b1;
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                build_number();
            end
            else if (kind == 7)
            begin
                build_number();
                pos = $urandom_range(0, txt.size() - 1);
                txt[pos] = ($urandom_range(0, 1) == 0) ? pick_blank()
                                                       : 8'($urandom_range(0, 255));
            end
            else if (kind == 8)
            begin
                repeat ($urandom_range(1, 6))
                    add_char(8'($urandom_range(0, 255)));
            end
            send_text($urandom_range(0, 7) == 0);
        end

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        while (items_taken != items_total || parse_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Ran %0d texts over %0d bytes; %0d values checked, %0d parsed, %0d rejected.",
                 texts_total, items_taken, results_seen, ok_seen, results_seen - ok_seen);
        if (errors == 0)
            $display("PASS decimal_text_to_int32_unit");
        else
            $display("FAIL decimal_text_to_int32_unit");
        $finish;
    end

endmodule

// ===== decimal_text_to_int32_unit.f =====
hw/rtl/dtoi_pkg.sv
hw/rtl/decimal_text_to_int32_unit.sv
sim/decimal_text_to_int32_unit_tb.sv
